@@ hdl/soft_pwm_rgb_fader_macros.svh @@
// Assertion macros shared by the fader RTL.
// Each macro carries its own clock and reset so the using module stays explicit.
`ifndef SOFT_PWM_RGB_FADER_MACROS_SVH
`define SOFT_PWM_RGB_FADER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SPRF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sprf: assertion failed");

// Next-cycle implication
`define SPRF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sprf: assertion failed");

`else

`define SPRF_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define SPRF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/sprf_pkg.sv @@
package sprf_pkg;

  // Field widths
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned PHASE_W = 8;
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned NUM_CH  = 3;
  localparam int unsigned NUM_PIN = 6;

  // Reset and fixed values
  localparam int unsigned FULL_SCALE_DEF = 127;
  localparam int unsigned DUTY_MAX       = 127;
  localparam logic [PHASE_W-1:0] PWM_LIMIT_RST   = 8'd127;
  localparam logic [TICKS_W-1:0] FADE_PERIOD_RST = 16'd100;
  localparam logic [TICKS_W-1:0] TICKS_SAT       = 16'hFFFF;
  localparam logic [7:0]         BYTE_FULL       = 8'd255;

  // Item operations
  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_SET_RGB     = 2'd1,
    OP_SET_CHANNEL = 2'd2,
    OP_START_FADE  = 2'd3
  } op_t;

  // Channel select codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Register indexes (byte address 4*index)
  localparam logic [1:0] REG_PWM_LIMIT      = 2'd0;
  localparam logic [1:0] REG_HEADLIGHT_DUTY = 2'd1;
  localparam logic [1:0] REG_LASER_DUTY     = 2'd2;
  localparam logic [1:0] REG_LASER_POWER    = 2'd3;

  // Pin bit positions
  localparam int unsigned PIN_RED        = 0;
  localparam int unsigned PIN_GREEN      = 1;
  localparam int unsigned PIN_BLUE       = 2;
  localparam int unsigned PIN_HEADLIGHT  = 3;
  localparam int unsigned PIN_LASER_GATE = 4;
  localparam int unsigned PIN_LASER_PWM  = 5;

  // Input item payload, highest field first in the bit order
  typedef struct packed {
    logic [5:0]         pad;
    logic [TICKS_W-1:0] fade_interval;
    logic               fade_blue;
    logic               fade_green;
    logic               fade_red;
    logic [7:0]         byte_level;
    logic [1:0]         channel;
    logic [DUTY_W-1:0]  blue_level;
    logic [DUTY_W-1:0]  green_level;
    logic [DUTY_W-1:0]  red_level;
  } item_t;

  // Result item payload, highest field first in the bit order
  typedef struct packed {
    logic [3:0]        pad;
    logic [DUTY_W-1:0] blue_duty;
    logic [DUTY_W-1:0] green_duty;
    logic [DUTY_W-1:0] red_duty;
    logic              fading_active;
    logic              laser_pwm_out;
    logic              laser_gate_out;
    logic              headlight_out;
    logic              blue_out;
    logic              green_out;
    logic              red_out;
  } result_t;

  // One PWM pin update for a tick at the given phase
  function automatic logic pwm_level(logic cur, logic [PHASE_W-1:0] phase,
                                     logic [PHASE_W-1:0] duty, logic guarded,
                                     logic [PHASE_W-1:0] top);
    logic lvl;
    lvl = cur;
    if (phase == '0) begin
      if (duty != '0) lvl = 1'b1;
    end else if ((phase > duty) && (!guarded || (duty < top))) begin
      lvl = 1'b0;
    end
    return lvl;
  endfunction

endpackage

@@ hdl/soft_pwm_rgb_fader.sv @@
// Six-output PWM with an RGB breathing fader. Every item on the s_ side yields
// exactly one result on the m_ side, one item per clock when m_tready is high:
// the whole update is one combinational pass from the current state and the
// incoming item into the state registers and the result register, so the rate
// is set only by the output register draining. A tick item (operation 0) runs
// one PWM time slot on the shared phase counter and then one fade step; the
// other operations load colour duties or start fading and leave pins and phase
// untouched. Result pins and duties are the values after the item. The APB
// registers (pwm_limit, headlight_duty, laser_duty, laser_power at 0x0, 0x4,
// 0x8, 0xC) should be written only while no item is in flight.
`include "soft_pwm_rgb_fader_macros.svh"

module soft_pwm_rgb_fader #(
  parameter int unsigned FULL_SCALE = sprf_pkg::FULL_SCALE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // red_level[6:0], green_level[13:7], blue_level[20:14], channel[22:21],
  // byte_level[30:23], fade_red[31], fade_green[32], fade_blue[33],
  // fade_interval[49:34], zero fill [55:50]
  input  logic [55:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]  s_tuser,
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // red_out[0], green_out[1], blue_out[2], headlight_out[3], laser_gate_out[4],
  // laser_pwm_out[5], fading_active[6], red_duty[13:7], green_duty[20:14],
  // blue_duty[27:21], zero fill [31:28]
  output logic [31:0] m_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DW = sprf_pkg::DUTY_W;
  localparam int unsigned PW = sprf_pkg::PHASE_W;
  localparam int unsigned TW = sprf_pkg::TICKS_W;
  localparam int unsigned NC = sprf_pkg::NUM_CH;
  localparam int unsigned NP = sprf_pkg::NUM_PIN;
  // Effective full scale, capped by the duty register width
  localparam logic [DW-1:0] DUTY_TOP = DW'((FULL_SCALE < sprf_pkg::DUTY_MAX) ?
                                            FULL_SCALE : sprf_pkg::DUTY_MAX);

  // Configuration registers
  logic [PW-1:0] pwm_limit;
  logic [DW-1:0] headlight_duty;
  logic [DW-1:0] laser_duty;
  logic [PW-1:0] laser_power;

  // Block state
  logic [PW-1:0]         phase_count, phase_count_next;
  logic [NC-1:0][DW-1:0] duty, duty_next;
  logic [TW-1:0]         fade_ticks, fade_ticks_next;
  logic [TW-1:0]         fade_period, fade_period_next;
  logic                  ramp_up, ramp_up_next;
  logic                  fade_seen, fade_seen_next;
  logic [NC-1:0]         fade_enable, fade_enable_next;
  logic [NP-1:0]         pin_levels, pin_levels_next;

  sprf_pkg::item_t   item;
  sprf_pkg::op_t     op;
  sprf_pkg::result_t result, result_next;
  logic              accept;
  logic              cfg_write;

  assign item   = sprf_pkg::item_t'(s_tdata);
  assign op     = sprf_pkg::op_t'(s_tuser);
  assign accept = s_tvalid && s_tready;

  // Output register: a new item is taken while the previous result drains
  assign s_tready = !m_tvalid || m_tready;
  assign m_tdata  = result;

  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_limit      <= sprf_pkg::PWM_LIMIT_RST;
      headlight_duty <= '0;
      laser_duty     <= '0;
      laser_power    <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        sprf_pkg::REG_PWM_LIMIT:      pwm_limit      <= pwdata[PW-1:0];
        sprf_pkg::REG_HEADLIGHT_DUTY: headlight_duty <= pwdata[DW-1:0];
        sprf_pkg::REG_LASER_DUTY:     laser_duty     <= pwdata[DW-1:0];
        sprf_pkg::REG_LASER_POWER:    laser_power    <= pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sprf_pkg::REG_PWM_LIMIT:      prdata = 32'(pwm_limit);
      sprf_pkg::REG_HEADLIGHT_DUTY: prdata = 32'(headlight_duty);
      sprf_pkg::REG_LASER_DUTY:     prdata = 32'(laser_duty);
      sprf_pkg::REG_LASER_POWER:    prdata = 32'(laser_power);
      default:                      prdata = '0;
    endcase
  end

  // Single-pass item update
  always_comb begin
    logic [PW:0]   phase_inc;
    logic          flip;
    logic [DW-1:0] byte_duty;

    phase_count_next = phase_count;
    duty_next        = duty;
    fade_ticks_next  = fade_ticks;
    fade_period_next = fade_period;
    ramp_up_next     = ramp_up;
    fade_seen_next   = fade_seen;
    fade_enable_next = fade_enable;
    pin_levels_next  = pin_levels;
    phase_inc        = {1'b0, phase_count} + (PW+1)'(1);
    flip             = 1'b0;
    byte_duty        = (item.byte_level == sprf_pkg::BYTE_FULL) ?
                       DUTY_TOP : item.byte_level[7:1];

    unique case (op)
      sprf_pkg::OP_TICK: begin
        // PWM slot on the current duties
        for (int c = 0; c < NC; c++) begin
          pin_levels_next[c] = sprf_pkg::pwm_level(pin_levels[c], phase_count,
                                 PW'(duty[c]), 1'b1, PW'(DUTY_TOP));
        end
        pin_levels_next[sprf_pkg::PIN_HEADLIGHT] =
          sprf_pkg::pwm_level(pin_levels[sprf_pkg::PIN_HEADLIGHT], phase_count,
                              PW'(headlight_duty), 1'b1, PW'(DUTY_TOP));
        pin_levels_next[sprf_pkg::PIN_LASER_GATE] =
          sprf_pkg::pwm_level(pin_levels[sprf_pkg::PIN_LASER_GATE], phase_count,
                              PW'(laser_duty), 1'b1, PW'(DUTY_TOP));
        pin_levels_next[sprf_pkg::PIN_LASER_PWM] =
          sprf_pkg::pwm_level(pin_levels[sprf_pkg::PIN_LASER_PWM], phase_count,
                              laser_power, 1'b0, PW'(DUTY_TOP));
        phase_count_next = (phase_inc > {1'b0, pwm_limit}) ? '0 : phase_inc[PW-1:0];

        // Fade step
        if (fade_enable != '0) begin
          fade_seen_next = 1'b1;
          if (fade_ticks > fade_period) begin
            for (int c = 0; c < NC; c++) begin
              if (fade_enable[c]) begin
                if (ramp_up) begin
                  if (duty[c] < DUTY_TOP) duty_next[c] = duty[c] + DW'(1);
                end else if (duty[c] != '0) begin
                  duty_next[c] = duty[c] - DW'(1);
                end
                if ((duty_next[c] == DUTY_TOP) || (duty_next[c] == '0)) flip = 1'b1;
              end
            end
            ramp_up_next    = ramp_up ^ flip;
            fade_ticks_next = TW'(1);
          end else if (fade_ticks != sprf_pkg::TICKS_SAT) begin
            fade_ticks_next = fade_ticks + TW'(1);
          end
        end else if (fade_seen) begin
          fade_ticks_next = '0;
          fade_seen_next  = 1'b0;
          ramp_up_next    = 1'b1;
        end
      end
      sprf_pkg::OP_SET_RGB: begin
        duty_next[0] = item.red_level;
        duty_next[1] = item.green_level;
        duty_next[2] = item.blue_level;
      end
      sprf_pkg::OP_SET_CHANNEL: begin
        case (item.channel)
          sprf_pkg::CH_RED:   duty_next[0] = byte_duty;
          sprf_pkg::CH_GREEN: duty_next[1] = byte_duty;
          sprf_pkg::CH_BLUE:  duty_next[2] = byte_duty;
          default: ;
        endcase
      end
      sprf_pkg::OP_START_FADE: begin
        duty_next        = '0;
        fade_ticks_next  = '0;
        fade_seen_next   = 1'b0;
        ramp_up_next     = 1'b1;
        fade_enable_next = {item.fade_blue, item.fade_green, item.fade_red};
        fade_period_next = item.fade_interval;
      end
      default: ;
    endcase

    // Result from the updated state
    result_next                = '0;
    result_next.red_out        = pin_levels_next[sprf_pkg::PIN_RED];
    result_next.green_out      = pin_levels_next[sprf_pkg::PIN_GREEN];
    result_next.blue_out       = pin_levels_next[sprf_pkg::PIN_BLUE];
    result_next.headlight_out  = pin_levels_next[sprf_pkg::PIN_HEADLIGHT];
    result_next.laser_gate_out = pin_levels_next[sprf_pkg::PIN_LASER_GATE];
    result_next.laser_pwm_out  = pin_levels_next[sprf_pkg::PIN_LASER_PWM];
    result_next.fading_active  = (fade_enable_next != '0);
    result_next.red_duty       = duty_next[0];
    result_next.green_duty     = duty_next[1];
    result_next.blue_duty      = duty_next[2];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      duty        <= '0;
      fade_ticks  <= '0;
      fade_period <= sprf_pkg::FADE_PERIOD_RST;
      ramp_up     <= 1'b1;
      fade_seen   <= 1'b0;
      fade_enable <= '0;
      pin_levels  <= '0;
    end else if (accept) begin
      phase_count <= phase_count_next;
      duty        <= duty_next;
      fade_ticks  <= fade_ticks_next;
      fade_period <= fade_period_next;
      ramp_up     <= ramp_up_next;
      fade_seen   <= fade_seen_next;
      fade_enable <= fade_enable_next;
      pin_levels  <= pin_levels_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) result <= result_next;
  end

  // Checks
  `SPRF_ASSERT_IMPL(a_idle_fade_clear, clk, rst, fade_enable == '0, !fade_seen && fade_ticks == '0)
  `SPRF_ASSERT_IMPL(a_seen_counts, clk, rst, fade_seen, fade_ticks != '0)
  `SPRF_ASSERT_IMPL(a_flag_matches, clk, rst, m_tvalid, result.fading_active == (fade_enable != '0))
  `SPRF_ASSERT_NEXT(a_non_tick_pins, clk, rst, accept && op != sprf_pkg::OP_TICK, $stable(pin_levels) && $stable(phase_count))

endmodule

@@ dv/tb_soft_pwm_rgb_fader.sv @@
`timescale 1ns / 1ps

module tb_soft_pwm_rgb_fader;

  // Duty value treated as full scale by the guard, the byte set and the ramp
  localparam int unsigned DUTY_TOP =
    (sprf_pkg::FULL_SCALE_DEF < sprf_pkg::DUTY_MAX) ? sprf_pkg::FULL_SCALE_DEF
                                                    : sprf_pkg::DUTY_MAX;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // red_level, green_level, blue_level, channel, byte_level, fade_red,
  // fade_green, fade_blue, fade_interval, zero fill
  logic [55:0] s_tdata = '0;
  // operation
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // red_out, green_out, blue_out, headlight_out, laser_gate_out, laser_pwm_out,
  // fading_active, red_duty, green_duty, blue_duty, zero fill
  logic [31:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  soft_pwm_rgb_fader uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the configuration registers
  logic [7:0] cfg_limit = sprf_pkg::PWM_LIMIT_RST;
  logic [6:0] cfg_head  = '0;
  logic [6:0] cfg_laser = '0;
  logic [7:0] cfg_power = '0;

  // Shadow of the fader state
  logic [7:0]  ph_cnt      = '0;
  logic [6:0]  duty_now[3] = '{default: '0};
  logic [15:0] fade_cnt    = '0;
  logic [15:0] fade_per    = sprf_pkg::FADE_PERIOD_RST;
  logic        ramp_dir_up = 1'b1;
  logic        fade_was_on = 1'b0;
  logic [2:0]  fade_mask   = '0;
  logic [5:0]  pin_q       = '0;

  sprf_pkg::result_t predicted_levels[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;

  // One pin over one PWM slot
  function automatic logic next_pin(logic cur, logic [7:0] phase, logic [7:0] d,
                                    logic guarded);
    if (phase == 8'd0)
      return (d != 8'd0) ? 1'b1 : cur;
    if (phase > d && (!guarded || d < DUTY_TOP))
      return 1'b0;
    return cur;
  endfunction

  // Apply one input item to the shadow state, return the pin/duty snapshot
  function automatic sprf_pkg::result_t advance_fader(sprf_pkg::op_t op,
                                                      sprf_pkg::item_t it);
    sprf_pkg::result_t r;
    logic flip;
    r = '0;
    case (op)
      sprf_pkg::OP_TICK: begin
        pin_q[sprf_pkg::PIN_RED] =
          next_pin(pin_q[sprf_pkg::PIN_RED], ph_cnt, {1'b0, duty_now[0]}, 1'b1);
        pin_q[sprf_pkg::PIN_GREEN] =
          next_pin(pin_q[sprf_pkg::PIN_GREEN], ph_cnt, {1'b0, duty_now[1]}, 1'b1);
        pin_q[sprf_pkg::PIN_BLUE] =
          next_pin(pin_q[sprf_pkg::PIN_BLUE], ph_cnt, {1'b0, duty_now[2]}, 1'b1);
        pin_q[sprf_pkg::PIN_HEADLIGHT] =
          next_pin(pin_q[sprf_pkg::PIN_HEADLIGHT], ph_cnt, {1'b0, cfg_head}, 1'b1);
        pin_q[sprf_pkg::PIN_LASER_GATE] =
          next_pin(pin_q[sprf_pkg::PIN_LASER_GATE], ph_cnt, {1'b0, cfg_laser}, 1'b1);
        pin_q[sprf_pkg::PIN_LASER_PWM] =
          next_pin(pin_q[sprf_pkg::PIN_LASER_PWM], ph_cnt, cfg_power, 1'b0);
        ph_cnt = (ph_cnt >= cfg_limit) ? 8'd0 : ph_cnt + 8'd1;
        // fade step after the PWM slot
        if (fade_mask != 3'b000) begin
          fade_was_on = 1'b1;
          if (fade_cnt > fade_per) begin
            flip = 1'b0;
            for (int c = 0; c < 3; c++) begin
              if (fade_mask[c]) begin
                if (ramp_dir_up) begin
                  if (duty_now[c] < DUTY_TOP) duty_now[c] = duty_now[c] + 7'd1;
                end else begin
                  if (duty_now[c] != 7'd0) duty_now[c] = duty_now[c] - 7'd1;
                end
                if (duty_now[c] == DUTY_TOP || duty_now[c] == 7'd0) flip = 1'b1;
              end
            end
            if (flip) ramp_dir_up = !ramp_dir_up;
            fade_cnt = '0;
          end
          if (fade_cnt != sprf_pkg::TICKS_SAT) fade_cnt = fade_cnt + 16'd1;
        end else if (fade_was_on) begin
          fade_cnt    = '0;
          fade_was_on = 1'b0;
          ramp_dir_up = 1'b1;
        end
      end
      sprf_pkg::OP_SET_RGB: begin
        duty_now[0] = it.red_level;
        duty_now[1] = it.green_level;
        duty_now[2] = it.blue_level;
      end
      sprf_pkg::OP_SET_CHANNEL: begin
        if (it.channel <= sprf_pkg::CH_BLUE)
          duty_now[it.channel] = (it.byte_level == sprf_pkg::BYTE_FULL) ?
                                 DUTY_TOP[6:0] : it.byte_level[7:1];
      end
      default: begin
        duty_now    = '{default: '0};
        fade_cnt    = '0;
        fade_was_on = 1'b0;
        ramp_dir_up = 1'b1;
        fade_mask   = {it.fade_blue, it.fade_green, it.fade_red};
        fade_per    = it.fade_interval;
      end
    endcase
    r.red_out        = pin_q[sprf_pkg::PIN_RED];
    r.green_out      = pin_q[sprf_pkg::PIN_GREEN];
    r.blue_out       = pin_q[sprf_pkg::PIN_BLUE];
    r.headlight_out  = pin_q[sprf_pkg::PIN_HEADLIGHT];
    r.laser_gate_out = pin_q[sprf_pkg::PIN_LASER_GATE];
    r.laser_pwm_out  = pin_q[sprf_pkg::PIN_LASER_PWM];
    r.fading_active  = (fade_mask != 3'b000);
    r.red_duty       = duty_now[0];
    r.green_duty     = duty_now[1];
    r.blue_duty      = duty_now[2];
    return r;
  endfunction

  task automatic note_mismatch(string what, int unsigned exp_v, int unsigned got_v);
    if (mismatches < 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
    mismatches++;
  endtask

  // Item predictor and result checker
  always @(posedge clk) begin
    sprf_pkg::result_t exp_r;
    sprf_pkg::result_t got_r;
    if (!rst) begin
      if (s_tvalid && s_tready)
        predicted_levels.push_back(advance_fader(sprf_pkg::op_t'(s_tuser),
                                                 sprf_pkg::item_t'(s_tdata)));
      if (m_tvalid && m_tready) begin
        got_r = sprf_pkg::result_t'(m_tdata);
        if (predicted_levels.size() == 0) begin
          note_mismatch("unexpected result item", 0, got_r);
        end else begin
          exp_r = predicted_levels.pop_front();
          if (got_r.red_out !== exp_r.red_out)
            note_mismatch("red_out", exp_r.red_out, got_r.red_out);
          if (got_r.green_out !== exp_r.green_out)
            note_mismatch("green_out", exp_r.green_out, got_r.green_out);
          if (got_r.blue_out !== exp_r.blue_out)
            note_mismatch("blue_out", exp_r.blue_out, got_r.blue_out);
          if (got_r.headlight_out !== exp_r.headlight_out)
            note_mismatch("headlight_out", exp_r.headlight_out, got_r.headlight_out);
          if (got_r.laser_gate_out !== exp_r.laser_gate_out)
            note_mismatch("laser_gate_out", exp_r.laser_gate_out, got_r.laser_gate_out);
          if (got_r.laser_pwm_out !== exp_r.laser_pwm_out)
            note_mismatch("laser_pwm_out", exp_r.laser_pwm_out, got_r.laser_pwm_out);
          if (got_r.fading_active !== exp_r.fading_active)
            note_mismatch("fading_active", exp_r.fading_active, got_r.fading_active);
          if (got_r.red_duty !== exp_r.red_duty)
            note_mismatch("red_duty", exp_r.red_duty, got_r.red_duty);
          if (got_r.green_duty !== exp_r.green_duty)
            note_mismatch("green_duty", exp_r.green_duty, got_r.green_duty);
          if (got_r.blue_duty !== exp_r.blue_duty)
            note_mismatch("blue_duty", exp_r.blue_duty, got_r.blue_duty);
        end
      end
    end
  end

  // Receiver backpressure: the mode is chosen at random each time its run ends
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_cyc  = 0;
  always @(posedge clk) begin
    rx_cyc++;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(32, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (rx_cyc % 4 != 0);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Register write through setup and access phases; starts on a clock edge
  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sprf_pkg::REG_PWM_LIMIT:      cfg_limit = value[7:0];
      sprf_pkg::REG_HEADLIGHT_DUTY: cfg_head  = value[6:0];
      sprf_pkg::REG_LASER_DUTY:     cfg_laser = value[6:0];
      default:                      cfg_power = value[7:0];
    endcase
  endtask

  // Send one item; the sender runs in bursts with random gaps in between
  task automatic send_item(sprf_pkg::op_t op, sprf_pkg::item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending and wait for every predicted result to come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic sprf_pkg::item_t rand_item();
    sprf_pkg::item_t it;
    it = '0;
    it.red_level     = 7'($urandom_range(0, 127));
    it.green_level   = 7'($urandom_range(0, 127));
    it.blue_level    = 7'($urandom_range(0, 127));
    it.channel       = 2'($urandom_range(0, 3));
    it.byte_level    = ($urandom_range(0, 5) == 0) ? sprf_pkg::BYTE_FULL
                                                   : 8'($urandom_range(0, 255));
    it.fade_red      = 1'($urandom_range(0, 1));
    it.fade_green    = 1'($urandom_range(0, 1));
    it.fade_blue     = 1'($urandom_range(0, 1));
    it.fade_interval = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  task automatic send_ticks(int unsigned n);
    repeat (n) send_item(sprf_pkg::OP_TICK, rand_item());
  endtask

  // Every operation, field extremes, bad channel, byte full scale
  task automatic test_directed_ops();
    sprf_pkg::item_t it;
    it = '0;
    send_ticks(2);
    it.red_level = 7'd127; it.green_level = 7'd127; it.blue_level = 7'd127;
    send_item(sprf_pkg::OP_SET_RGB, it);
    send_ticks(3);
    it.red_level = 7'd0; it.green_level = 7'd127; it.blue_level = 7'd0;
    send_item(sprf_pkg::OP_SET_RGB, it);
    it = '0; it.channel = sprf_pkg::CH_RED;   it.byte_level = 8'd255;
    send_item(sprf_pkg::OP_SET_CHANNEL, it);
    it = '0; it.channel = sprf_pkg::CH_GREEN; it.byte_level = 8'd254;
    send_item(sprf_pkg::OP_SET_CHANNEL, it);
    it = '0; it.channel = sprf_pkg::CH_BLUE;  it.byte_level = 8'd1;
    send_item(sprf_pkg::OP_SET_CHANNEL, it);
    // channel 3 selects nothing
    it = '0; it.channel = 2'd3; it.byte_level = 8'd255;
    send_item(sprf_pkg::OP_SET_CHANNEL, it);
    send_ticks(2);
    it = '0; it.fade_red = 1'b1; it.fade_green = 1'b1; it.fade_blue = 1'b1;
    it.fade_interval = 16'hFFFF;
    send_item(sprf_pkg::OP_START_FADE, it);
    send_ticks(3);
    it.fade_interval = 16'd0;
    send_item(sprf_pkg::OP_START_FADE, it);
    send_ticks(5);
    // fading off
    it = '0;
    send_item(sprf_pkg::OP_START_FADE, it);
    send_ticks(2);
    drain_results();
  endtask

  // Register extremes; each setting gets a short run of ticks
  task automatic test_config_extremes();
    apb_write(sprf_pkg::REG_PWM_LIMIT, 32'd0);
    apb_write(sprf_pkg::REG_HEADLIGHT_DUTY, 32'd127);
    apb_write(sprf_pkg::REG_LASER_DUTY, 32'd0);
    apb_write(sprf_pkg::REG_LASER_POWER, 32'd255);
    send_ticks(6);
    drain_results();
    apb_write(sprf_pkg::REG_PWM_LIMIT, 32'd1);
    apb_write(sprf_pkg::REG_HEADLIGHT_DUTY, 32'd0);
    apb_write(sprf_pkg::REG_LASER_DUTY, 32'd127);
    apb_write(sprf_pkg::REG_LASER_POWER, 32'd0);
    send_ticks(6);
    drain_results();
    apb_write(sprf_pkg::REG_PWM_LIMIT, 32'd255);
    apb_write(sprf_pkg::REG_HEADLIGHT_DUTY, 32'd1);
    apb_write(sprf_pkg::REG_LASER_DUTY, 32'd126);
    apb_write(sprf_pkg::REG_LASER_POWER, 32'd128);
    send_ticks(8);
    drain_results();
  endtask

  // Random fading sessions and noise under one register setting
  task automatic test_random_traffic(int unsigned n_items, bit extreme_cfg);
    sprf_pkg::item_t it;
    int unsigned sent;
    int unsigned run;
    sent = 0;
    if (extreme_cfg) begin
      apb_write(sprf_pkg::REG_PWM_LIMIT,
                ($urandom_range(0, 1) != 0) ? 32'd255 : 32'd0);
      apb_write(sprf_pkg::REG_HEADLIGHT_DUTY,
                ($urandom_range(0, 1) != 0) ? 32'd127 : 32'd0);
      apb_write(sprf_pkg::REG_LASER_DUTY,
                ($urandom_range(0, 1) != 0) ? 32'd127 : 32'd0);
      apb_write(sprf_pkg::REG_LASER_POWER,
                ($urandom_range(0, 1) != 0) ? 32'd255 : 32'd0);
    end else begin
      apb_write(sprf_pkg::REG_PWM_LIMIT,
                ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(0, 15));
      apb_write(sprf_pkg::REG_HEADLIGHT_DUTY, $urandom_range(0, 127));
      apb_write(sprf_pkg::REG_LASER_DUTY, $urandom_range(0, 127));
      apb_write(sprf_pkg::REG_LASER_POWER, $urandom_range(0, 255));
    end
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        // start fading, optionally preload colours, then a run of ticks with occasional channel sets
        it = rand_item();
        if ($urandom_range(0, 7) != 0 &&
            {it.fade_red, it.fade_green, it.fade_blue} == 3'b000)
          it.fade_red = 1'b1;
        if ($urandom_range(0, 7) != 0) it.fade_interval = 16'($urandom_range(0, 3));
        send_item(sprf_pkg::OP_START_FADE, it);
        sent++;
        if ($urandom_range(0, 1) != 0) begin
          it = rand_item();
          if ($urandom_range(0, 1) != 0) begin
            it.red_level   = 7'($urandom_range(120, 127));
            it.green_level = 7'($urandom_range(120, 127));
            it.blue_level  = 7'($urandom_range(120, 127));
          end
          send_item(sprf_pkg::OP_SET_RGB, it);
          sent++;
        end
        run = $urandom_range(10, 100);
        repeat (run) begin
          if ($urandom_range(0, 9) == 0) send_item(sprf_pkg::OP_SET_CHANNEL, rand_item());
          else send_item(sprf_pkg::OP_TICK, rand_item());
          sent++;
        end
      end else begin
        // noise: any operation, any field values
        run = $urandom_range(1, 12);
        repeat (run) begin
          send_item(sprf_pkg::op_t'(2'($urandom_range(0, 3))), rand_item());
          sent++;
        end
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_ops();
    test_config_extremes();
    test_random_traffic(200, 1'b0);
    test_random_traffic(200, 1'b1);
    test_random_traffic(200, 1'b0);
    test_random_traffic(200, 1'b0);
    repeat (10) @(posedge clk);
    if (predicted_levels.size() != 0)
      note_mismatch("results never seen", predicted_levels.size(), 0);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
